[hdl/indexed_list_deque_unit_defines.svh]
// Assertion macros for the indexed list deque unit.
// Used by the checker module; expects clk_i and rst_ni in scope.
`ifndef INDEXED_LIST_DEQUE_UNIT_DEFINES_SVH
`define INDEXED_LIST_DEQUE_UNIT_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent
`define ILD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent
`define ILD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ild_pkg.sv]
// Shared types and codes for the indexed list deque unit.
// No dependencies; imported by the cell, controller, top level and checker.
`default_nettype none

package ild_pkg;

  // Position width wide enough for any supported depth (up to 256)
  localparam int PosW = 9;
  localparam int ValW = 32;

  // Operation codes
  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_POP_FRONT  = 3'd1,
    FUNC_PUSH_BACK  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_INSERT     = 3'd4,
    FUNC_REMOVE     = 3'd5,
    FUNC_PEEK       = 3'd6,
    FUNC_NOP        = 3'd7
  } func_e;

  // Status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic [PosW-1:0]        pos;
    logic signed [ValW-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/ild_cell.sv]
// One storage cell of the list chain: holds one entry, shifts with neighbors.
// Depends on ild_pkg for the broadcast command type.
`default_nettype none

module ild_cell #(
  parameter int Idx = 0
) (
  input  logic                               clk_i,
  input  ild_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [ild_pkg::ValW-1:0]    left_i,
  input  logic signed [ild_pkg::ValW-1:0]    right_i,
  output logic signed [ild_pkg::ValW-1:0]    value_o,
  output logic                               hit_o
);
  import ild_pkg::*;

  localparam logic [PosW-1:0] Self = PosW'(Idx);

  logic signed [ValW-1:0] value_q, value_d;
  logic                   at_pos, past_pos;

  // Compare own index against the target position
  assign at_pos   = (ctrl_i.pos == Self);
  assign past_pos = (Self > ctrl_i.pos);

  // Open a gap on insert, close it on remove, else hold
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (at_pos) begin
        value_d = ctrl_i.value;
      end else if (past_pos) begin
        value_d = left_i;
      end
    end else if (ctrl_i.rem) begin
      if (at_pos || past_pos) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign hit_o   = at_pos;

endmodule

`default_nettype wire

[hdl/ild_ctrl.sv]
// Operation decode, entry count and result register for the list unit.
// Depends on ild_pkg for codes and the cell command type.
`default_nettype none

module ild_ctrl #(
  parameter int Depth = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [2:0]                      func_i,
  input  logic signed [ild_pkg::ValW-1:0] value_in_i,
  input  logic [4:0]                      position_i,
  input  logic signed [ild_pkg::ValW-1:0] rd_value_i,
  output ild_pkg::cell_ctrl_t             ctrl_o,
  output logic                            valid_o,
  output logic signed [ild_pkg::ValW-1:0] value_out_o,
  output logic [1:0]                      status_o,
  output logic [4:0]                      entry_count_o
);
  import ild_pkg::*;

  localparam int CntW = $clog2(Depth + 1);

  logic [CntW-1:0]        count_q, count_d;
  logic                   valid_q;
  logic signed [ValW-1:0] value_q, value_d;
  logic [1:0]             status_q, status_d;
  logic [PosW-1:0]        cnt_ext, pos_ext;
  logic                   full, empty, ins, rem, rd;
  func_e                  func;

  assign func    = func_e'(func_i);
  assign cnt_ext = PosW'(count_q);
  assign pos_ext = PosW'(position_i);
  assign full    = (count_q == CntW'(Depth));
  assign empty   = (count_q == '0);

  // Decode the operation into a shift command and a status
  always_comb begin
    ins          = 1'b0;
    rem          = 1'b0;
    rd           = 1'b0;
    status_d     = StOk;
    ctrl_o.pos   = pos_ext;
    ctrl_o.value = value_in_i;
    unique case (func)
      FUNC_PUSH_FRONT: begin
        ctrl_o.pos = '0;
        if (full) status_d = StFull;
        else ins = 1'b1;
      end
      FUNC_POP_FRONT: begin
        ctrl_o.pos = '0;
        if (empty) status_d = StRange;
        else rem = 1'b1;
      end
      FUNC_PUSH_BACK: begin
        ctrl_o.pos = cnt_ext;
        if (full) status_d = StFull;
        else ins = 1'b1;
      end
      FUNC_POP_BACK: begin
        ctrl_o.pos = cnt_ext - PosW'(1);
        if (empty) status_d = StRange;
        else rem = 1'b1;
      end
      FUNC_INSERT: begin
        if (pos_ext > cnt_ext) status_d = StRange;
        else if (full) status_d = StFull;
        else ins = 1'b1;
      end
      FUNC_REMOVE: begin
        if (pos_ext >= cnt_ext) status_d = StRange;
        else rem = 1'b1;
      end
      FUNC_PEEK: begin
        if (pos_ext >= cnt_ext) status_d = StRange;
        else rd = 1'b1;
      end
      default: begin
      end
    endcase
    ctrl_o.ins = start_i && ins;
    ctrl_o.rem = start_i && rem;
  end

  // Return the entry taken or read, zero otherwise
  assign value_d = (rem || rd) ? rd_value_i : '0;

  // Advance the count with each accepted shift
  always_comb begin
    count_d = count_q;
    if (ctrl_o.ins) count_d = count_q + CntW'(1);
    else if (ctrl_o.rem) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= start_i;
    end
  end

  // Hold the result payload for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign valid_o       = valid_q;
  assign value_out_o   = value_q;
  assign status_o      = status_q;
  assign entry_count_o = cnt_ext[4:0];

endmodule

`default_nettype wire

[hdl/indexed_list_deque_unit.sv]
// Indexed list with deque operations, built as a chain of shifting cells.
// The result is registered: its strobe comes in the cycle after the item is accepted.
// Throughput: one item per cycle; every cell compares its index and shifts in parallel.
// busy_o stays low; the receiver cannot stall and results are strobed once.
// Reset clears the entry count and strobe; entry contents are not cleared.
`default_nettype none

module indexed_list_deque_unit #(
  parameter int DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [2:0]                      func_i,
  input  logic signed [ild_pkg::ValW-1:0] value_in_i,
  input  logic [4:0]                      position_i,
  output logic                            valid_o,
  output logic signed [ild_pkg::ValW-1:0] value_out_o,
  output logic [1:0]                      status_o,
  output logic [4:0]                      entry_count_o
);
  import ild_pkg::*;

  cell_ctrl_t             ctrl;
  logic signed [ValW-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]       cell_hit;
  logic signed [ValW-1:0] rd_value;

  // Every operation completes without stalling, so busy is never raised
  assign busy_o = 1'b0;

  ild_ctrl #(
    .Depth(DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .func_i       (func_i),
    .value_in_i   (value_in_i),
    .position_i   (position_i),
    .rd_value_i   (rd_value),
    .ctrl_o       (ctrl),
    .valid_o      (valid_o),
    .value_out_o  (value_out_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  // Chain of cells, each linked to its neighbors; the ends take zero on the left and their own value on the right
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_val[i];
    end else begin : g_mid_r
      assign right = cell_val[i+1];
    end

    ild_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left),
      .right_i(right),
      .value_o(cell_val[i]),
      .hit_o  (cell_hit[i])
    );
  end

  // Pick the entry of the cell that matches the position
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | (cell_val[i] & {ValW{cell_hit[i]}});
    end
  end

endmodule

`default_nettype wire

[hdl/ild_checker.sv]
// Port-level checker for the indexed list deque unit, bound to the top level.
// Depends on ild_pkg and the assertion macros header.
`default_nettype none
`include "indexed_list_deque_unit_defines.svh"

module ild_checker #(
  parameter int DEPTH = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            valid_o,
  input logic signed [ild_pkg::ValW-1:0] value_out_o,
  input logic [1:0]                      status_o,
  input logic [4:0]                      entry_count_o
);
  import ild_pkg::*;

  logic accept;
  logic err_res;
  logic full_res;
  assign accept   = start_i && !busy_o;
  assign err_res  = valid_o && (status_o != StOk);
  assign full_res = valid_o && (status_o == StFull);

  // Each accepted item yields exactly one result in the next cycle
  `ILD_ASSERT_NEXT(a_result_follows, accept, valid_o, "accepted item gave no result")
  `ILD_ASSERT_NEXT(a_no_stray_result, !accept, !valid_o, "result without an item")

  // Failed operations leave the count alone and return zero
  `ILD_ASSERT(a_err_count, err_res |-> entry_count_o == $past(entry_count_o), "count moved")
  `ILD_ASSERT(a_err_zero_value, err_res |-> value_out_o == '0, "nonzero value on error")

  // A full status only occurs when the list held the maximum number of entries
  `ILD_ASSERT(a_full_status, full_res |-> $past(entry_count_o) == 5'(DEPTH), "full below depth")

endmodule

bind indexed_list_deque_unit ild_checker #(.DEPTH(DEPTH)) u_ild_checker (.*);

`default_nettype wire
